// File: sv/ps2mpt_pkg.sv
// Shared types, constants and helpers for the PS/2 mouse position tracker.
package ps2mpt_pkg;

  localparam int CFG_W       = 9;    // widest configuration register
  localparam int CFG_IDX_W   = 2;
  localparam int BYTE_W      = 8;
  localparam int BUTTON_W    = 3;
  localparam int CELL_W      = 8;
  localparam int DELTA_W     = 14;   // scaled delta, also holds the negated Y move
  localparam int SCALED_W    = 18;   // byte times speed, before the divide by eight

  localparam int SYNC_BIT    = 3;
  localparam int X_OVF_BIT   = 6;
  localparam int Y_OVF_BIT   = 7;

  localparam int COUNT_MAX   = 256;
  localparam int SPEED_RESET = 240;
  localparam int COLS_RESET  = 80;
  localparam int ROWS_RESET  = 25;
  localparam int X_HOME_CELL = 40;
  localparam int Y_HOME_CELL = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED   = 2'd0,
    REG_COLUMNS = 2'd1,
    REG_ROWS    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } phase_e;

  typedef struct packed {
    logic                     we;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         data;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;      // already negated: added to the row position
    logic [BUTTON_W-1:0]       buttons;
  } pkt_t;

  // Clamp a written value into 1..256.
  function automatic logic [CFG_W-1:0] sat_count(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (int'(v) > COUNT_MAX) begin
      r = CFG_W'(COUNT_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/ps2_mouse_packet_position_tracker.sv
// Top level: PS/2 mouse packet framer and clamped pointer position tracker.
// Path: the third packet byte passes the byte register, the scaled packet register,
// the position register and the output register before its result is valid.
// Throughput: one byte per cycle when not stalled; at most one result every 3 bytes.
// Reset: asynchronous, clears the framer and restores speed 240, 80 x 25 cells
// and the pointer at column 40, row 12; no clearing pass, ready right after reset.
module ps2_mouse_packet_position_tracker #(
  parameter int SUBCELL_SCALE = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [ps2mpt_pkg::BYTE_W-1:0]           mouse_byte_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [ps2mpt_pkg::CELL_W-1:0]           column_o,
  output logic [ps2mpt_pkg::CELL_W-1:0]           row_o,
  output logic [ps2mpt_pkg::BUTTON_W-1:0]         button_bits_o,
  input  logic                                    cfg_we_i,
  input  logic [ps2mpt_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ps2mpt_pkg::CFG_W-1:0]            cfg_wdata_i
);

  localparam int POS_W = $clog2(ps2mpt_pkg::COUNT_MAX * SUBCELL_SCALE);

  ps2mpt_pkg::cfg_wr_t             cfg;
  ps2mpt_pkg::pkt_t                pkt;
  logic                            pkt_vld, pkt_rdy;
  logic                            res_vld, res_rdy;
  logic [POS_W-1:0]                x_pos, y_pos;
  logic [ps2mpt_pkg::BUTTON_W-1:0] buttons;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  ps2mpt_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mouse_byte_i (mouse_byte_i),
    .cfg_i        (cfg),
    .pkt_rdy_i    (pkt_rdy),
    .pkt_vld_o    (pkt_vld),
    .pkt_o        (pkt)
  );

  ps2mpt_track #(
    .SUBCELL_SCALE (SUBCELL_SCALE)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .pkt_vld_i (pkt_vld),
    .pkt_i     (pkt),
    .pkt_rdy_o (pkt_rdy),
    .res_rdy_i (res_rdy),
    .res_vld_o (res_vld),
    .x_pos_o   (x_pos),
    .y_pos_o   (y_pos),
    .buttons_o (buttons)
  );

  ps2mpt_out #(
    .SUBCELL_SCALE (SUBCELL_SCALE)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_vld_i     (res_vld),
    .res_rdy_o     (res_rdy),
    .x_pos_i       (x_pos),
    .y_pos_i       (y_pos),
    .buttons_i     (buttons),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .column_o      (column_o),
    .row_o         (row_o),
    .button_bits_o (button_bits_o)
  );

endmodule

// File: sv/ps2mpt_frame.sv
// Byte input register, 3-byte packet framer and delta scaling.
module ps2mpt_frame (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ps2mpt_pkg::BYTE_W-1:0]       mouse_byte_i,
  input  ps2mpt_pkg::cfg_wr_t                 cfg_i,
  input  logic                                pkt_rdy_i,
  output logic                                pkt_vld_o,
  output ps2mpt_pkg::pkt_t                    pkt_o
);

  localparam int DW = ps2mpt_pkg::DELTA_W;
  localparam int SW = ps2mpt_pkg::SCALED_W;
  localparam int BW = ps2mpt_pkg::BYTE_W;

  logic                          byte_vld_q, byte_vld_d;
  logic [BW-1:0]                 byte_q;
  ps2mpt_pkg::phase_e            phase_q, phase_d;
  logic [BW-1:0]                 flag_q;
  logic [BW-1:0]                 xbyte_q;
  logic [ps2mpt_pkg::CFG_W-1:0]  speed_q;
  logic                          pkt_vld_q, pkt_vld_d;
  ps2mpt_pkg::pkt_t              pkt_q, pkt_d;

  logic pkt_free, in_rdy;
  logic byte_take, flag_ld, x_ld, pkt_ld;
  logic [BW-1:0] dx_raw, dy_raw;

  // d * speed / 8, truncated toward zero
  function automatic logic signed [DW-1:0] scale(input logic [BW-1:0] d,
                                                 input logic [ps2mpt_pkg::CFG_W-1:0] spd);
    logic signed [SW-1:0] prod;
    prod = SW'($signed(d)) * $signed({1'b0, spd});
    if (prod < 0) begin
      prod = prod + SW'(7);
    end
    return DW'(prod >>> 3);
  endfunction

  assign pkt_free = !pkt_vld_q || pkt_rdy_i;

  // framer outputs
  always_comb begin
    byte_take = 1'b0;
    flag_ld   = 1'b0;
    x_ld      = 1'b0;
    pkt_ld    = 1'b0;
    if (byte_vld_q) begin
      unique case (phase_q)
        ps2mpt_pkg::PH_FLAG: begin
          byte_take = 1'b1;
          flag_ld   = byte_q[ps2mpt_pkg::SYNC_BIT];
        end
        ps2mpt_pkg::PH_X: begin
          byte_take = 1'b1;
          x_ld      = 1'b1;
        end
        ps2mpt_pkg::PH_Y: begin
          byte_take = pkt_free;
          pkt_ld    = pkt_free;
        end
        default: begin
          byte_take = 1'b1;
        end
      endcase
    end
  end

  // framer next state; a flag byte without the sync bit is dropped
  always_comb begin
    phase_d = phase_q;
    if (byte_take) begin
      unique case (phase_q)
        ps2mpt_pkg::PH_FLAG: begin
          if (byte_q[ps2mpt_pkg::SYNC_BIT]) begin
            phase_d = ps2mpt_pkg::PH_X;
          end
        end
        ps2mpt_pkg::PH_X: begin
          phase_d = ps2mpt_pkg::PH_Y;
        end
        ps2mpt_pkg::PH_Y: begin
          phase_d = ps2mpt_pkg::PH_FLAG;
        end
        default: begin
          phase_d = ps2mpt_pkg::PH_FLAG;
        end
      endcase
    end
  end

  assign in_rdy     = !byte_vld_q || byte_take;
  assign in_stall_o = !in_rdy;

  always_comb begin
    byte_vld_d = byte_vld_q;
    if (in_valid_i && in_rdy) begin
      byte_vld_d = 1'b1;
    end else if (byte_take) begin
      byte_vld_d = 1'b0;
    end
  end

  assign dx_raw = flag_q[ps2mpt_pkg::X_OVF_BIT] ? '0 : xbyte_q;
  assign dy_raw = flag_q[ps2mpt_pkg::Y_OVF_BIT] ? '0 : byte_q;

  always_comb begin
    pkt_d         = pkt_q;
    pkt_vld_d     = pkt_vld_q;
    if (pkt_ld) begin
      pkt_d.dx      = scale(dx_raw, speed_q);
      pkt_d.dy      = -scale(dy_raw, speed_q);
      pkt_d.buttons = flag_q[ps2mpt_pkg::BUTTON_W-1:0];
      pkt_vld_d     = 1'b1;
    end else if (pkt_rdy_i) begin
      pkt_vld_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      phase_q    <= ps2mpt_pkg::PH_FLAG;
      flag_q     <= '0;
      xbyte_q    <= '0;
      speed_q    <= ps2mpt_pkg::CFG_W'(ps2mpt_pkg::SPEED_RESET);
      pkt_vld_q  <= 1'b0;
    end else begin
      byte_vld_q <= byte_vld_d;
      phase_q    <= phase_d;
      pkt_vld_q  <= pkt_vld_d;
      if (flag_ld) begin
        flag_q <= byte_q;
      end
      if (x_ld) begin
        xbyte_q <= byte_q;
      end
      if (cfg_i.we && cfg_i.idx == ps2mpt_pkg::REG_SPEED) begin
        speed_q <= ps2mpt_pkg::sat_count(cfg_i.data);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_rdy) begin
      byte_q <= mouse_byte_i;
    end
    pkt_q <= pkt_d;
  end

  assign pkt_vld_o = pkt_vld_q;
  assign pkt_o     = pkt_q;

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q != '0 && int'(speed_q) <= ps2mpt_pkg::COUNT_MAX)
    else $error("speed register out of range");

  a_pkt_from_third_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pkt_vld_q) |-> $past(phase_q) == ps2mpt_pkg::PH_Y)
    else $error("packet issued outside the third byte");

endmodule

// File: sv/ps2mpt_track.sv
// Sub-cell position registers, screen bounds and clamping.
module ps2mpt_track #(
  parameter int  SUBCELL_SCALE = 8,
  localparam int POS_W         = $clog2(ps2mpt_pkg::COUNT_MAX * SUBCELL_SCALE)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ps2mpt_pkg::cfg_wr_t                 cfg_i,
  input  logic                                pkt_vld_i,
  input  ps2mpt_pkg::pkt_t                    pkt_i,
  output logic                                pkt_rdy_o,
  input  logic                                res_rdy_i,
  output logic                                res_vld_o,
  output logic [POS_W-1:0]                    x_pos_o,
  output logic [POS_W-1:0]                    y_pos_o,
  output logic [ps2mpt_pkg::BUTTON_W-1:0]     buttons_o
);

  localparam int DW    = ps2mpt_pkg::DELTA_W;
  localparam int CW    = ps2mpt_pkg::CFG_W;
  localparam int SUM_W = ((POS_W + 1 > DW) ? POS_W + 1 : DW) + 1;

  logic [POS_W-1:0]                x_q, x_d, y_q, y_d;
  logic [CW-1:0]                   cols_q, cols_d, rows_q, rows_d;
  logic                            res_vld_q, res_vld_d;
  logic [ps2mpt_pkg::BUTTON_W-1:0] btn_q;
  logic                            pkt_take;

  function automatic logic [POS_W-1:0] bound_of(input logic [CW-1:0] cnt);
    return POS_W'(int'(cnt) * SUBCELL_SCALE - 1);
  endfunction

  function automatic logic [POS_W-1:0] move_clamp(input logic [POS_W-1:0] pos,
                                                  input logic signed [DW-1:0] delta,
                                                  input logic [POS_W-1:0] bound);
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        r;
    sum = SUM_W'($signed({1'b0, pos})) + SUM_W'(delta);
    if (sum < 0) begin
      r = '0;
    end else if (sum > SUM_W'($signed({1'b0, bound}))) begin
      r = bound;
    end else begin
      r = POS_W'(sum);
    end
    return r;
  endfunction

  assign pkt_rdy_o = !res_vld_q || res_rdy_i;
  assign pkt_take  = pkt_vld_i && pkt_rdy_o;

  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    cols_d    = cols_q;
    rows_d    = rows_q;
    res_vld_d = res_vld_q;
    if (pkt_take) begin
      x_d       = move_clamp(x_q, pkt_i.dx, bound_of(cols_q));
      y_d       = move_clamp(y_q, pkt_i.dy, bound_of(rows_q));
      res_vld_d = 1'b1;
    end else begin
      if (res_rdy_i) begin
        res_vld_d = 1'b0;
      end
      // new bounds pull the pointer back on screen
      if (cfg_i.we && cfg_i.idx == ps2mpt_pkg::REG_COLUMNS) begin
        cols_d = ps2mpt_pkg::sat_count(cfg_i.data);
        if (x_q > bound_of(cols_d)) begin
          x_d = bound_of(cols_d);
        end
      end
      if (cfg_i.we && cfg_i.idx == ps2mpt_pkg::REG_ROWS) begin
        rows_d = ps2mpt_pkg::sat_count(cfg_i.data);
        if (y_q > bound_of(rows_d)) begin
          y_d = bound_of(rows_d);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= POS_W'(ps2mpt_pkg::X_HOME_CELL * SUBCELL_SCALE);
      y_q       <= POS_W'(ps2mpt_pkg::Y_HOME_CELL * SUBCELL_SCALE);
      cols_q    <= CW'(ps2mpt_pkg::COLS_RESET);
      rows_q    <= CW'(ps2mpt_pkg::ROWS_RESET);
      res_vld_q <= 1'b0;
      btn_q     <= '0;
    end else begin
      x_q       <= x_d;
      y_q       <= y_d;
      cols_q    <= cols_d;
      rows_q    <= rows_d;
      res_vld_q <= res_vld_d;
      if (pkt_take) begin
        btn_q <= pkt_i.buttons;
      end
    end
  end

  assign res_vld_o = res_vld_q;
  assign x_pos_o   = x_q;
  assign y_pos_o   = y_q;
  assign buttons_o = btn_q;

  a_x_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_q <= bound_of(cols_q))
    else $error("x position beyond column bound");

  a_y_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    y_q <= bound_of(rows_q))
    else $error("y position beyond row bound");

endmodule

// File: sv/ps2mpt_out.sv
// Sub-cell to cell conversion and the result output register.
module ps2mpt_out #(
  parameter int  SUBCELL_SCALE = 8,
  localparam int POS_W         = $clog2(ps2mpt_pkg::COUNT_MAX * SUBCELL_SCALE)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                res_vld_i,
  output logic                                res_rdy_o,
  input  logic [POS_W-1:0]                    x_pos_i,
  input  logic [POS_W-1:0]                    y_pos_i,
  input  logic [ps2mpt_pkg::BUTTON_W-1:0]     buttons_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ps2mpt_pkg::CELL_W-1:0]       column_o,
  output logic [ps2mpt_pkg::CELL_W-1:0]       row_o,
  output logic [ps2mpt_pkg::BUTTON_W-1:0]     button_bits_o
);

  // pos / SUBCELL_SCALE as (pos * RECIP) >> SHIFT_K, exact for every pos below 2**POS_W
  localparam int SHIFT_K = POS_W + $clog2(SUBCELL_SCALE);
  localparam int RECIP_W = POS_W + 1;
  localparam int PROD_W  = POS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** SHIFT_K) + SUBCELL_SCALE - 1) / SUBCELL_SCALE);
  localparam int CLW = ps2mpt_pkg::CELL_W;

  logic              out_vld_q, out_vld_d;
  logic              load;
  logic [PROD_W-1:0] x_prod, y_prod;
  logic [CLW-1:0]    col_q, row_q;
  logic [ps2mpt_pkg::BUTTON_W-1:0] btn_q;

  assign res_rdy_o = !out_vld_q || !out_stall_i;
  assign load      = res_vld_i && res_rdy_o;

  assign x_prod = PROD_W'(x_pos_i) * PROD_W'(RECIP);
  assign y_prod = PROD_W'(y_pos_i) * PROD_W'(RECIP);

  always_comb begin
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      col_q <= x_prod[SHIFT_K +: CLW];
      row_q <= y_prod[SHIFT_K +: CLW];
      btn_q <= buttons_i;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign column_o      = col_q;
  assign row_o         = row_q;
  assign button_bits_o = btn_q;

endmodule

// File: dv/ps2_mouse_packet_position_tracker_test.sv
// Self-checking testbench for the PS/2 mouse packet position tracker.
`timescale 1ns / 1ps

module ps2_mouse_packet_position_tracker_test;

  localparam int SUBCELL         = 8;
  localparam int SPEED_UNIT      = 8;     // speed is given in eighths
  localparam int PHASES          = 9;
  localparam int BYTES_PER_PHASE = 200;
  localparam int HOLD_PHASE      = 2;
  localparam int HOLD_BURST      = 90;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE          = 8;
  localparam int DRAIN_LIMIT     = 20000;
  localparam int DIRECTED_ROWS   = 24;

  localparam logic [ps2mpt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [ps2mpt_pkg::CELL_W-1:0]   column;
    logic [ps2mpt_pkg::CELL_W-1:0]   row;
    logic [ps2mpt_pkg::BUTTON_W-1:0] buttons;
  } pointer_t;

  typedef struct packed {
    logic [ps2mpt_pkg::BYTE_W-1:0] data;
    logic                          typed;
    pointer_t                      want;
  } directed_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic [ps2mpt_pkg::BYTE_W-1:0]    mouse_byte_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic [ps2mpt_pkg::CELL_W-1:0]    column_o;
  logic [ps2mpt_pkg::CELL_W-1:0]    row_o;
  logic [ps2mpt_pkg::BUTTON_W-1:0]  button_bits_o;
  logic                             cfg_we_i;
  logic [ps2mpt_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [ps2mpt_pkg::CFG_W-1:0]     cfg_wdata_i;

  ps2_mouse_packet_position_tracker #(
    .SUBCELL_SCALE(SUBCELL)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mouse_byte_i (mouse_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .column_o     (column_o),
    .row_o        (row_o),
    .button_bits_o(button_bits_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Pointer tracker state, mirrored from the packet stream.
  int                 pointer_speed;
  int                 screen_cols;
  int                 screen_rows;
  ps2mpt_pkg::phase_e frame_phase;
  logic [7:0]         flags_held;
  logic [7:0]         x_byte_held;
  int                 x_sub;
  int                 y_sub;

  pointer_t pending_positions[$];
  int       mismatches;
  int       reports_checked;
  int       bytes_sent;
  int       dropped_bytes;
  int       reg_writes;
  int       holdoff_requests;
  int       burst_left;

  // One mouse byte per row; typed rows are read straight off
  // the default 80 x 25 screen at speed 240, where every full-scale delta hits a bound.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    {8'h00, 1'b0, 19'd0},                        // lost sync: dropped
    {8'h08, 1'b0, 19'd0},
    {8'h00, 1'b0, 19'd0},
    {8'h00, 1'b1, 8'd40, 8'd12, 3'd0},           // no motion: home position
    {8'h0F, 1'b0, 19'd0},
    {8'h7F, 1'b0, 19'd0},
    {8'h80, 1'b1, 8'd79, 8'd24, 3'd7},           // right and down edges
    {8'h38, 1'b0, 19'd0},
    {8'h80, 1'b0, 19'd0},
    {8'h7F, 1'b1, 8'd0, 8'd0, 3'd0},             // left and top edges
    {8'hC9, 1'b0, 19'd0},
    {8'h7F, 1'b0, 19'd0},
    {8'h7F, 1'b1, 8'd0, 8'd0, 3'd1},             // both overflow flags: no move
    {8'h4A, 1'b0, 19'd0},
    {8'h00, 1'b0, 19'd0},
    {8'h80, 1'b1, 8'd0, 8'd24, 3'd2},            // X overflow only
    {8'h8C, 1'b0, 19'd0},
    {8'h7F, 1'b0, 19'd0},
    {8'h01, 1'b1, 8'd79, 8'd24, 3'd4},           // Y overflow only
    {8'hF7, 1'b0, 19'd0},                        // sync bit clear: dropped
    {8'h00, 1'b0, 19'd0},
    {8'h08, 1'b0, 19'd0},
    {8'h00, 1'b0, 19'd0},
    {8'h01, 1'b0, 19'd0}
  };

  int preset_speed [5] = '{0, 8, 511, 1, 256};
  int preset_cols  [5] = '{0, 256, 257, 200, 1};
  int preset_rows  [5] = '{511, 1, 300, 256, 2};

  function automatic int fit_to_screen(input int pos, input int cells);
    int top;
    top = cells * SUBCELL - 1;
    if (pos < 0) return 0;
    if (pos > top) return top;
    return pos;
  endfunction

  function automatic int clip_setting(input logic [ps2mpt_pkg::CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (int'(raw) > ps2mpt_pkg::COUNT_MAX) return ps2mpt_pkg::COUNT_MAX;
    return int'(raw);
  endfunction

  function automatic void apply_register_write(input logic [ps2mpt_pkg::CFG_IDX_W-1:0] idx,
                                               input logic [ps2mpt_pkg::CFG_W-1:0] raw);
    case (idx)
      ps2mpt_pkg::REG_SPEED: pointer_speed = clip_setting(raw);
      ps2mpt_pkg::REG_COLUMNS: begin
        screen_cols = clip_setting(raw);
        x_sub = fit_to_screen(x_sub, screen_cols);
      end
      ps2mpt_pkg::REG_ROWS: begin
        screen_rows = clip_setting(raw);
        y_sub = fit_to_screen(y_sub, screen_rows);
      end
      default: ;
    endcase
  endfunction

  // Advances the framer by one byte; returns 1 with the new report when a packet completes.
  function automatic bit frame_byte(input logic [7:0] b, output pointer_t report);
    int dx;
    int dy;
    report = '0;
    case (frame_phase)
      ps2mpt_pkg::PH_FLAG: begin
        if (!b[ps2mpt_pkg::SYNC_BIT]) begin
          dropped_bytes++;
          return 1'b0;
        end
        flags_held = b;
        frame_phase = ps2mpt_pkg::PH_X;
        return 1'b0;
      end
      ps2mpt_pkg::PH_X: begin
        x_byte_held = b;
        frame_phase = ps2mpt_pkg::PH_Y;
        return 1'b0;
      end
      default: begin
        frame_phase = ps2mpt_pkg::PH_FLAG;
        dx = flags_held[ps2mpt_pkg::X_OVF_BIT] ? 0 : int'($signed(x_byte_held));
        dy = flags_held[ps2mpt_pkg::Y_OVF_BIT] ? 0 : int'($signed(b));
        dx = (dx * pointer_speed) / SPEED_UNIT;
        dy = (dy * pointer_speed) / SPEED_UNIT;
        x_sub = fit_to_screen(x_sub + dx, screen_cols);
        y_sub = fit_to_screen(y_sub - dy, screen_rows);
        report.column  = 8'(x_sub / SUBCELL);
        report.row     = 8'(y_sub / SUBCELL);
        report.buttons = flags_held[ps2mpt_pkg::BUTTON_W-1:0];
        return 1'b1;
      end
    endcase
  endfunction

  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] delta_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(0, 8) - 4);
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0: return 8'h7F;
        1: return 8'h80;
        2: return 8'h01;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom);
  endfunction

  function automatic logic [ps2mpt_pkg::CFG_W-1:0] pick_count();
    if ($urandom_range(0, 1) == 1) return 9'($urandom_range(1, 40));
    return 9'($urandom_range(0, 511));
  endfunction

  // Entered just after the clock rises; returns in the step in which the byte is taken.
  task automatic offer_byte(input logic [7:0] b);
    in_valid_i   <= 1'b1;
    mouse_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic sender_gap(input bit steady);
    int gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if (!steady && $urandom_range(0, 1) == 1) begin
      gap = idle_length();
    end
    if (gap > 0) begin
      in_valid_i   <= 1'b0;
      mouse_byte_i <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit steady);
    pointer_t report;
    offer_byte(b);
    if (frame_byte(b, report)) pending_positions.push_back(report);
    sender_gap(steady);
  endtask

  task automatic send_packet();
    logic [7:0] flags;
    bit steady;
    flags = 8'($urandom);
    flags[ps2mpt_pkg::SYNC_BIT]  = 1'b1;
    flags[ps2mpt_pkg::X_OVF_BIT] = ($urandom_range(0, 7) == 0);
    flags[ps2mpt_pkg::Y_OVF_BIT] = ($urandom_range(0, 7) == 0);
    steady = ($urandom_range(0, 4) == 0);
    send_byte(flags, steady);
    send_byte(delta_byte(), steady);
    send_byte(delta_byte(), steady);
  endtask

  task automatic write_register(input logic [ps2mpt_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ps2mpt_pkg::CFG_W-1:0] raw);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= raw;
    @(posedge clk_i);
    apply_register_write(idx, raw);
    reg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    int spins;
    spins = 0;
    while (pending_positions.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Receiver: random stalls, quiet stretches, and a long hold-off on request.
  initial begin : receiver
    int stall_left;
    int free_left;
    int served;
    int r;
    stall_left = 0;
    free_left  = 0;
    served     = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_requests > served) begin
        served++;
        stall_left = LONG_HOLD - 1;
        free_left  = 0;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          stall_left = idle_length() - 1;
          out_stall_i <= 1'b1;
        end else if (r < 92) begin
          free_left = $urandom_range(0, 6);
          out_stall_i <= 1'b0;
        end else begin
          free_left = $urandom_range(40, 120);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    pointer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      reports_checked++;
      if (pending_positions.size() == 0) begin
        $display("%0t: report with nothing pending: column %0d row %0d buttons %0d",
                 $time, column_o, row_o, button_bits_o);
        mismatches++;
      end else begin
        want = pending_positions.pop_front();
        if (column_o !== want.column) begin
          $display("%0t: column expected %0d, got %0d", $time, want.column, column_o);
          mismatches++;
        end
        if (row_o !== want.row) begin
          $display("%0t: row expected %0d, got %0d", $time, want.row, row_o);
          mismatches++;
        end
        if (button_bits_o !== want.buttons) begin
          $display("%0t: button_bits expected %0d, got %0d", $time, want.buttons,
                   button_bits_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #1_500_000;
    $display("%0t: timeout with %0d reports outstanding", $time, pending_positions.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    pointer_t report;
    int target;
    int spd;
    int cols;
    int rows;
    mismatches       = 0;
    reports_checked  = 0;
    bytes_sent       = 0;
    dropped_bytes    = 0;
    reg_writes       = 0;
    holdoff_requests = 0;
    burst_left       = 0;
    pointer_speed    = ps2mpt_pkg::SPEED_RESET;
    screen_cols      = ps2mpt_pkg::COLS_RESET;
    screen_rows      = ps2mpt_pkg::ROWS_RESET;
    frame_phase      = ps2mpt_pkg::PH_FLAG;
    flags_held       = '0;
    x_byte_held      = '0;
    x_sub            = ps2mpt_pkg::X_HOME_CELL * SUBCELL;
    y_sub            = ps2mpt_pkg::Y_HOME_CELL * SUBCELL;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mouse_byte_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= ps2mpt_pkg::REG_SPEED;
    cfg_wdata_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_byte(directed_rows[i].data);
      if (frame_byte(directed_rows[i].data, report))
        pending_positions.push_back(directed_rows[i].typed ? directed_rows[i].want : report);
      sender_gap(1'b0);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      if (ph < 5) begin
        spd  = preset_speed[ph];
        cols = preset_cols[ph];
        rows = preset_rows[ph];
      end else begin
        spd  = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 16) : $urandom_range(0, 511);
        cols = pick_count();
        rows = pick_count();
      end
      write_register(ps2mpt_pkg::REG_COLUMNS, 9'(cols));
      write_register(ps2mpt_pkg::REG_ROWS, 9'(rows));
      write_register(ps2mpt_pkg::REG_SPEED, 9'(spd));
      write_register(REG_SPARE, 9'($urandom));

      if (ph == HOLD_PHASE) begin
        // back-to-back transfers against a long receiver hold-off
        holdoff_requests++;
        burst_left = HOLD_BURST;
      end
      target = bytes_sent - dropped_bytes + BYTES_PER_PHASE;
      while (bytes_sent - dropped_bytes < target) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray bytes, then finish whatever packet they opened
          repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
          while (frame_phase != ps2mpt_pkg::PH_FLAG) send_byte(8'($urandom), 1'b0);
        end else begin
          send_packet();
        end
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    if (pending_positions.size() != 0)
      $display("%0t: %0d expected reports never arrived", $time, pending_positions.size());
    $display("Sent %0d mouse bytes (%0d dropped out of sync), checked %0d pointer reports",
             bytes_sent, dropped_bytes, reports_checked);
    $display("Made %0d register writes over %0d screen and speed settings, extremes included",
             reg_writes, PHASES + 1);
    if (mismatches == 0 && pending_positions.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
